// ===== hdl/bb3_pkg.sv =====
// shared types, constants and the reciprocal table of the 3x3 box blur
// no dependencies; imported by bb3_lane, bb3_merge and the top level
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = NUM_CH * CH_W;
    localparam int ROW_W     = 16;
    localparam int OUT_COL_W = 10;

    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = 13;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam int LANES      = 4;
    localparam int LANE_IDX_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;
    localparam int M_USED_W  = PIX_W + ROW_W + OUT_COL_W;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = 16'd768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } cfg_reg_t;

    // channel 0 red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

    // [row][col], row 2 and col 2 hold the arriving pixel
    typedef pixel_t [2:0][2:0] window_t;

    typedef struct packed {
        logic                 en;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 frame_done;
    } lane_meta_t;

    // ceil(2^20 / (2*cnt)) for the neighbour counts a 3x3 window can have
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/bb3_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bb3_lane.sv =====
// one blur lane: masked 3x3 sums, then mean by reciprocal multiply
// depends on bb3_pkg
module bb3_lane (
    input  logic             aclk,
    input  logic             load_sum,
    input  logic             load_quot,
    input  bb3_pkg::window_t win,
    input  logic [2:0]       row_mask,
    input  logic [2:0]       col_mask,
    output bb3_pkg::pixel_t  pix_out
);
    import bb3_pkg::*;

    logic [SUM_W-1:0]  sum_next [NUM_CH];
    logic [SUM_W-1:0]  sum_reg  [NUM_CH];
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [1:0]        rows_n;
    logic [1:0]        cols_n;
    logic [RECIP_W-1:0] recip_m;
    logic [NUM_W-1:0]  num      [NUM_CH];
    logic [PROD_W-1:0] prod     [NUM_CH];
    pixel_t            quot_next;
    pixel_t            pix_reg;

    always_comb begin
        rows_n   = 2'(row_mask[0]) + 2'(row_mask[1]) + 2'(row_mask[2]);
        cols_n   = 2'(col_mask[0]) + 2'(col_mask[1]) + 2'(col_mask[2]);
        cnt_next = CNT_W'(rows_n) * CNT_W'(cols_n);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum_next[ch] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (row_mask[i] && col_mask[j]) begin
                        sum_next[ch] = sum_next[ch] + SUM_W'(win[i][j][ch]);
                    end
                end
            end
        end
    end

    // (2*sum + cnt) / (2*cnt)
    always_comb begin
        recip_m = recip(cnt_reg);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            num[ch]       = {sum_reg[ch], 1'b0} + NUM_W'(cnt_reg);
            prod[ch]      = PROD_W'(num[ch]) * PROD_W'(recip_m);
            quot_next[ch] = prod[ch][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_sum) begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
        if (load_quot) begin
            pix_reg <= quot_next;
        end
    end

    assign pix_out = pix_reg;

endmodule

// ===== hdl/bb3_merge.sv =====
// merge stage: collects the lane results of one pixel and sends them in lane order
// depends on bb3_pkg
module bb3_merge (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load_valid,
    output logic                            load_ready,
    input  bb3_pkg::lane_meta_t             meta [bb3_pkg::LANES],
    input  bb3_pkg::pixel_t                 pix  [bb3_pkg::LANES],
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bb3_pkg::M_TDATA_W-1:0]   m_tdata,  // red, green, blue, row, col, zero pad
    output logic                            m_tlast,
    output logic                            m_tuser   // frame_done
);
    import bb3_pkg::*;

    logic [LANES-1:0]      slot_valid_reg;
    logic [LANES-1:0]      slot_valid_next;
    logic [LANES-1:0]      slot_last_reg;
    lane_meta_t            slot_meta_reg [LANES];
    pixel_t                slot_pix_reg  [LANES];
    logic [LANES-1:0]      en_vec;
    logic [LANES-1:0]      last_vec;
    logic                  higher;
    logic [LANE_IDX_W-1:0] sel;
    logic                  load;

    assign load_ready = !(|slot_valid_reg);
    assign load       = load_valid && load_ready;

    always_comb begin
        higher = 1'b0;
        for (int k = LANES - 1; k >= 0; k--) begin
            en_vec[k]   = meta[k].en;
            last_vec[k] = meta[k].en && !higher;
            higher      = higher || meta[k].en;
        end
    end

    always_comb begin
        sel = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (slot_valid_reg[k]) begin
                sel = LANE_IDX_W'(k);
            end
        end
    end

    always_comb begin
        slot_valid_next = slot_valid_reg;
        if (load) begin
            slot_valid_next = en_vec;
        end else if (m_tvalid && m_tready) begin
            slot_valid_next[sel] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else begin
            slot_valid_reg <= slot_valid_next;
        end
        if (load) begin
            slot_last_reg <= last_vec;
            slot_meta_reg <= meta;
            slot_pix_reg  <= pix;
        end
    end

    assign m_tvalid = |slot_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, slot_meta_reg[sel].col,
                       slot_meta_reg[sel].row, slot_pix_reg[sel]};
    assign m_tlast  = slot_last_reg[sel];
    assign m_tuser  = slot_meta_reg[sel].frame_done;

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("results left after last beat of a pixel");

    a_last_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == ($countones(slot_valid_reg) == 1)))
        else $error("tlast does not mark the final pending result");

    a_drop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready && m_tlast))
        else $error("result dropped before last beat was taken");

endmodule

// ===== hdl/box_blur_3x3_rgb_top.sv =====
// top level of the 3x3 box blur: config, counters, line store, lanes, merge
// depends on bb3_pkg, bb3_ram, bb3_lane, bb3_merge
//
// Usage:
//   s_t* carries 24-bit RGB pixels in raster order, one beat per pixel.
//   m_t* carries blurred pixels with their row and column; tlast marks the
//   final result caused by one input pixel, tuser the bottom-right pixel.
//   cfg_* writes image_width (index 0) or image_height (index 1); a write
//   restarts the frame at row 0, column 0. Width 0 acts as 1, widths above
//   MAX_WIDTH saturate, height 0 acts as 1. cfg_ready is always high.
//   An input pixel gives 0 to 4 results; they pass the input, lane sum, lane
//   quotient and output slot registers, then leave one per clock while m_tready is high.
//   One pixel is in flight at a time: the line store is read at acceptance and
//   written back the next clock; a new pixel is taken once the previous one has
//   moved into the output slots, which is delayed while earlier results are still pending there.
//   A stalled receiver holds the results in the output slots; one further
//   pixel may be taken and waits before the slots until they drain.
//   Reset (aresetn low at a clock edge) restores width 1024 and height 768,
//   clears the counters and drops pending results. The line store needs no
//   clearing: entries from an earlier frame never reach a result.
module box_blur_3x3_rgb_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bb3_pkg::S_TDATA_W-1:0]    s_tdata,   // in_red, in_green, in_blue
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bb3_pkg::M_TDATA_W-1:0]    m_tdata,   // out_red, out_green, out_blue,
                                                        // out_row, out_col, zero pad
    output logic                             m_tlast,   // last_of_run
    output logic                             m_tuser,   // frame_done
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bb3_pkg::*;

    logic [WCFG_W-1:0] width_cfg_reg;
    logic [HCFG_W-1:0] height_cfg_reg;
    logic [ADDR_W:0]   width_eff;
    logic [HCFG_W-1:0] height_eff;
    logic              cfg_write;
    logic              cfg_restart;

    logic [ADDR_W-1:0] col_count_reg;
    logic [ADDR_W-1:0] col_count_next;
    logic [ROW_W-1:0]  row_count_reg;
    logic [ROW_W-1:0]  row_count_next;
    logic              col_last;
    logic              row_last;
    logic              accept;

    logic              a_valid_reg;
    logic              b_valid_reg;
    logic              c_valid_reg;
    logic              merge_ready;

    pixel_t            a_pix_reg;
    logic [ROW_W-1:0]  a_row_reg;
    logic [ADDR_W-1:0] a_col_reg;
    logic              a_col_last_reg;
    logic              a_row_last_reg;

    logic [2*PIX_W-1:0] ram_rdata;
    pixel_t             above_rd;
    pixel_t             two_above_rd;
    pixel_t             upper_reg  [2][2];
    pixel_t             recent_reg [2];
    window_t            win;

    logic              r_ge1;
    logic              r_ge2;
    logic              c_ge1;
    logic              c_ge2;
    logic [2:0]        rmask_up;
    logic [2:0]        rmask_cur;
    logic [2:0]        cmask_left;
    logic [2:0]        cmask_here;
    logic [2:0]        lane_rmask [LANES];
    logic [2:0]        lane_cmask [LANES];
    lane_meta_t        lane_meta  [LANES];
    pixel_t            lane_pix   [LANES];
    logic [ROW_W-1:0]     row_up;
    logic [OUT_COL_W-1:0] col_left;
    logic [OUT_COL_W-1:0] col_here;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_write
                         && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});

    always_comb begin
        if (width_cfg_reg == '0) begin
            width_eff = (ADDR_W + 1)'(1);
        end else if (32'(width_cfg_reg) > MAX_WIDTH) begin
            width_eff = (ADDR_W + 1)'(MAX_WIDTH);
        end else begin
            width_eff = (ADDR_W + 1)'(width_cfg_reg);
        end
        height_eff = (height_cfg_reg == '0) ? HCFG_W'(1) : height_cfg_reg;
    end

    assign s_tready = !(a_valid_reg || b_valid_reg || c_valid_reg);
    assign accept   = s_tvalid && s_tready;

    assign col_last = ((ADDR_W + 1)'(col_count_reg) + (ADDR_W + 1)'(1)) == width_eff;
    assign row_last = ((ROW_W + 1)'(row_count_reg) + (ROW_W + 1)'(1))
                      == (ROW_W + 1)'(height_eff);

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_restart) begin
            col_count_next = '0;
            row_count_next = '0;
        end else if (accept) begin
            if (col_last) begin
                col_count_next = '0;
                row_count_next = row_last ? '0 : row_count_reg + ROW_W'(1);
            end else begin
                col_count_next = col_count_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[WCFG_W-1:0];
                    REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[HCFG_W-1:0];
                    default: ;
                endcase
            end
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            a_valid_reg   <= accept;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg || (c_valid_reg && !merge_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pix_reg      <= s_tdata[PIX_W-1:0];
            a_row_reg      <= row_count_reg;
            a_col_reg      <= col_count_reg;
            a_col_last_reg <= col_last;
            a_row_last_reg <= row_last;
        end
        if (a_valid_reg) begin
            upper_reg[0][0] <= upper_reg[0][1];
            upper_reg[0][1] <= two_above_rd;
            upper_reg[1][0] <= upper_reg[1][1];
            upper_reg[1][1] <= above_rd;
            recent_reg[0]   <= recent_reg[1];
            recent_reg[1]   <= a_pix_reg;
        end
    end

    // one entry per column: {two rows above, row above}
    bb3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (aclk),
        .we    (a_valid_reg),
        .waddr (a_col_reg),
        .wdata ({above_rd, a_pix_reg}),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (ram_rdata)
    );

    assign two_above_rd = ram_rdata[2*PIX_W-1:PIX_W];
    assign above_rd     = ram_rdata[PIX_W-1:0];

    always_comb begin
        win[0][0] = upper_reg[0][0];
        win[0][1] = upper_reg[0][1];
        win[0][2] = two_above_rd;
        win[1][0] = upper_reg[1][0];
        win[1][1] = upper_reg[1][1];
        win[1][2] = above_rd;
        win[2][0] = recent_reg[0];
        win[2][1] = recent_reg[1];
        win[2][2] = a_pix_reg;
    end

    assign r_ge1 = a_row_reg != '0;
    assign r_ge2 = a_row_reg > ROW_W'(1);
    assign c_ge1 = a_col_reg != '0;
    assign c_ge2 = a_col_reg > ADDR_W'(1);

    assign rmask_up   = {1'b1, r_ge1, r_ge2};
    assign rmask_cur  = {1'b1, r_ge1, 1'b0};
    assign cmask_left = {1'b1, c_ge1, c_ge2};
    assign cmask_here = {1'b1, c_ge1, 1'b0};

    assign row_up   = a_row_reg - ROW_W'(1);
    assign col_left = OUT_COL_W'(a_col_reg - ADDR_W'(1));
    assign col_here = OUT_COL_W'(a_col_reg);

    // lanes: row above left, row above here, this row left, this row here
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            lane_rmask[k] = (k < 2) ? rmask_up : rmask_cur;
            lane_cmask[k] = (k == 0 || k == 2) ? cmask_left : cmask_here;
        end
        lane_meta[0] = '{en: r_ge1 && c_ge1, row: row_up, col: col_left,
                         frame_done: 1'b0};
        lane_meta[1] = '{en: r_ge1 && a_col_last_reg, row: row_up, col: col_here,
                         frame_done: 1'b0};
        lane_meta[2] = '{en: a_row_last_reg && c_ge1, row: a_row_reg, col: col_left,
                         frame_done: 1'b0};
        lane_meta[3] = '{en: a_row_last_reg && a_col_last_reg, row: a_row_reg,
                         col: col_here, frame_done: 1'b1};
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bb3_lane u_lane (
            .aclk      (aclk),
            .load_sum  (a_valid_reg),
            .load_quot (b_valid_reg),
            .win       (win),
            .row_mask  (lane_rmask[g]),
            .col_mask  (lane_cmask[g]),
            .pix_out   (lane_pix[g])
        );
    end

    bb3_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (c_valid_reg),
        .load_ready (merge_ready),
        .meta       (lane_meta),
        .pix        (lane_pix),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({a_valid_reg, b_valid_reg, c_valid_reg}))
        else $error("more than one pixel in flight");

    a_sum_to_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |=> b_valid_reg)
        else $error("lane sum stage lost a pixel");

    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (ADDR_W + 1)'(col_count_reg) < width_eff)
        else $error("column counter outside frame");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg < height_eff)
        else $error("row counter outside frame");

endmodule
